### rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Item layouts, command codes, execution states and the blank cell value.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned COLS_DEF  = 80;
  localparam int unsigned ROWS_DEF  = 25;
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 2;

  localparam logic [15:0] BLANK_CELL     = 16'h0720;
  localparam logic [7:0]  CH_LF          = 8'h0A;
  localparam logic [7:0]  CH_CR          = 8'h0D;
  localparam logic [7:0]  TEXT_COLOR_RST = 8'h0F;

  // input mode codes; 5 to 7 mean nothing
  typedef enum logic [2:0] {
    MODE_WRITE  = 3'd0,
    MODE_PUT    = 3'd1,
    MODE_SETCUR = 3'd2,
    MODE_READ   = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  // classified command, as queued between front and back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_CHAR,
    OP_NEWLINE,
    OP_PUT,
    OP_SETCUR,
    OP_READ,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_BLANK
  } exec_state_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [6:0] col;
    logic [4:0] line;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col_out;
    logic [4:0]  cursor_row_out;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [15:0] cell_word;
    logic [6:0]  col;
    logic [4:0]  row;
  } cmd_t;

endpackage

### rtl/core/tcw_fifo.sv
// ----------------------------------------------------------------------------
// tcw_fifo: small synchronous queue
// Register-based FIFO with show-ahead read; used for commands and results.
// ----------------------------------------------------------------------------
module tcw_fifo #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] rdata_o,
  output logic          empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == NW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

### rtl/core/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: item decoder
// Holds the text colour register and turns each input item into a command
// with range checks and cursor clamping already applied.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int unsigned COLS = tcw_pkg::COLS_DEF,
  parameter int unsigned ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcw_pkg::in_item_t item_i,
  input  logic             cfg_valid_i,
  input  logic [7:0]       cfg_data_i,
  output tcw_pkg::cmd_t    cmd_o
);

  import tcw_pkg::*;

  logic [7:0] text_color_q;
  logic       col_ok, row_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= TEXT_COLOR_RST;
    end else if (cfg_valid_i) begin
      text_color_q <= cfg_data_i;
    end
  end

  assign col_ok = ({1'b0, item_i.col} < 8'(COLS));
  assign row_ok = ({1'b0, item_i.line} < 6'(ROWS));

  always_comb begin
    cmd_o.op        = OP_NOP;
    cmd_o.cell_word = {item_i.cell_color, item_i.char_code};
    cmd_o.col       = item_i.col;
    cmd_o.row       = item_i.line;
    case (item_i.mode)
      MODE_WRITE: begin
        cmd_o.cell_word = {text_color_q, item_i.char_code};
        if (item_i.char_code == CH_LF) begin
          cmd_o.op = OP_NEWLINE;
        end else if (item_i.char_code != CH_CR) begin
          cmd_o.op = OP_CHAR;
        end
      end
      MODE_PUT: begin
        if (col_ok && row_ok) begin
          cmd_o.op = OP_PUT;
        end
      end
      MODE_SETCUR: begin
        cmd_o.op  = OP_SETCUR;
        cmd_o.col = col_ok ? item_i.col : 7'(COLS - 1);
        cmd_o.row = row_ok ? item_i.line : 5'(ROWS - 1);
      end
      MODE_READ: begin
        // out of range reads report zero, same as a no-op
        if (col_ok && row_ok) begin
          cmd_o.op = OP_READ;
        end
      end
      MODE_CLEAR: begin
        cmd_o.op = OP_CLEAR;
      end
      default: begin
        cmd_o.op = OP_NOP;
      end
    endcase
  end

endmodule

### rtl/core/tcw_exec.sv
// ----------------------------------------------------------------------------
// tcw_exec: command executor
// Owns the cell store and cursor. Rows are kept in a ring with a base row,
// so a scroll only moves the base and blanks one row.
// ----------------------------------------------------------------------------
module tcw_exec #(
  parameter int unsigned COLS = tcw_pkg::COLS_DEF,
  parameter int unsigned ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcw_pkg::cmd_t      cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output tcw_pkg::out_item_t res_o,
  output logic               booting_o
);

  import tcw_pkg::*;

  localparam int unsigned CW = $clog2(COLS);
  localparam int unsigned RW = $clog2(ROWS);
  localparam int unsigned AW = CW + RW;
  localparam int unsigned MEM_DEPTH = ROWS << CW;

  exec_state_e state_q, state_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [RW-1:0] base_q, base_d;
  logic [RW-1:0] sweep_row_q, sweep_row_d;
  logic [CW-1:0] sweep_col_q, sweep_col_d;
  logic          booting_q, booting_d;

  logic [15:0]   mem [MEM_DEPTH];
  logic [15:0]   rdata_q;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata;

  logic [RW-1:0] cmd_prow, cur_prow, base_inc;
  logic [RW:0]   sum_cmd, sum_cur;

  // logical row to physical row: base + row, wrapped once
  assign sum_cmd  = {1'b0, base_q} + {1'b0, cmd_i.row[RW-1:0]};
  assign sum_cur  = {1'b0, base_q} + {1'b0, cur_row_q};
  assign cmd_prow = (sum_cmd >= (RW+1)'(ROWS)) ? RW'(sum_cmd - (RW+1)'(ROWS)) : RW'(sum_cmd);
  assign cur_prow = (sum_cur >= (RW+1)'(ROWS)) ? RW'(sum_cur - (RW+1)'(ROWS)) : RW'(sum_cur);
  assign base_inc = (base_q == RW'(ROWS - 1)) ? '0 : base_q + 1'b1;

  assign raddr     = {cmd_prow, cmd_i.col[CW-1:0]};
  assign booting_o = booting_q;

  always_comb begin
    state_d     = state_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    base_d      = base_q;
    sweep_row_d = sweep_row_q;
    sweep_col_d = sweep_col_q;
    booting_d   = booting_q;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    we          = 1'b0;
    waddr       = {cmd_prow, cmd_i.col[CW-1:0]};
    wdata       = cmd_i.cell_word;
    res_o.cell_value = '0;

    case (state_q)
      ST_INIT: begin
        // whole-store blanking, physical rows in order
        we    = 1'b1;
        waddr = {sweep_row_q, sweep_col_q};
        wdata = BLANK_CELL;
        if (sweep_col_q == CW'(COLS - 1)) begin
          sweep_col_d = '0;
          if (sweep_row_q == RW'(ROWS - 1)) begin
            sweep_row_d = '0;
            booting_d   = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            sweep_row_d = sweep_row_q + 1'b1;
          end
        end else begin
          sweep_col_d = sweep_col_q + 1'b1;
        end
      end
      ST_BLANK: begin
        // blank the row freed by a scroll
        we    = 1'b1;
        waddr = {sweep_row_q, sweep_col_q};
        wdata = BLANK_CELL;
        if (sweep_col_q == CW'(COLS - 1)) begin
          sweep_col_d = '0;
          sweep_row_d = '0;
          state_d     = ST_IDLE;
        end else begin
          sweep_col_d = sweep_col_q + 1'b1;
        end
      end
      ST_READ: begin
        res_push_o       = 1'b1;
        res_o.cell_value = rdata_q;
        state_d          = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o  = 1'b1;
          res_push_o = 1'b1;
          case (cmd_i.op)
            OP_CHAR, OP_NEWLINE: begin
              if (cmd_i.op == OP_CHAR) begin
                we    = 1'b1;
                waddr = {cur_prow, cur_col_q};
              end
              if (cmd_i.op == OP_CHAR && cur_col_q != CW'(COLS - 1)) begin
                cur_col_d = cur_col_q + 1'b1;
              end else begin
                cur_col_d = '0;
                if (cur_row_q == RW'(ROWS - 1)) begin
                  // scroll: old top row becomes the new bottom row
                  base_d      = base_inc;
                  sweep_row_d = base_q;
                  sweep_col_d = '0;
                  state_d     = ST_BLANK;
                end else begin
                  cur_row_d = cur_row_q + 1'b1;
                end
              end
            end
            OP_PUT: begin
              we = 1'b1;
            end
            OP_SETCUR: begin
              cur_col_d = cmd_i.col[CW-1:0];
              cur_row_d = cmd_i.row[RW-1:0];
            end
            OP_READ: begin
              res_push_o = 1'b0;
              state_d    = ST_READ;
            end
            OP_CLEAR: begin
              cur_col_d   = '0;
              cur_row_d   = '0;
              base_d      = '0;
              sweep_row_d = '0;
              sweep_col_d = '0;
              state_d     = ST_INIT;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_o.cursor_col_out = 7'(cur_col_d);
    res_o.cursor_row_out = 5'(cur_row_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      base_q      <= '0;
      sweep_row_q <= '0;
      sweep_col_q <= '0;
      booting_q   <= 1'b1;
    end else begin
      state_q     <= state_d;
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      base_q      <= base_d;
      sweep_row_q <= sweep_row_d;
      sweep_col_q <= sweep_col_d;
      booting_q   <= booting_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

endmodule

### rtl/core/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit: text console with cursor, scroll and clear
// Decoder front, command queue, executor over a ring-organised cell store,
// result queue.
// ----------------------------------------------------------------------------
//
//  channel   | ports                              | accepted when
//  ----------+------------------------------------+---------------------------
//  items in  | push, full, in_item_i              | push && !full
//  results   | pop, empty, out_item_o             | pop && !empty
//  colour    | cfg_valid_i, cfg_ready_o, cfg_data_i | cfg_valid_i && cfg_ready_o
//
//  Flow: an item's result enters the result queue when the executor takes
//  the item from the command queue; a read's result follows from the read
//  state (the store read is registered). One item a cycle can be queued
//  while full is low. A write that scrolls then blanks the new bottom row.
//  Clear sweeps the whole store; scrolling is cheap because rows live in
//  a ring addressed from a base row. After reset the same sweep runs while
//  full is held high. A full result queue stalls the executor and so the
//  command queue; a full command queue does not stall the results.
//
module text_console_writer_unit #(
  parameter int unsigned COLS = tcw_pkg::COLS_DEF,
  parameter int unsigned ROWS = tcw_pkg::ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item input
  input  logic               push,
  output logic               full,
  input  tcw_pkg::in_item_t  in_item_i,
  // results
  input  logic               pop,
  output logic               empty,
  output tcw_pkg::out_item_t out_item_o,
  // text colour register
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_data_i
);

  import tcw_pkg::*;

  cmd_t      cmd_in, cmd_head;
  logic      cmd_full, cmd_empty, cmd_pop;
  out_item_t res_in;
  logic      res_full, res_push;
  logic      booting;

  // register is always writable; it only feeds the decoder
  assign cfg_ready_o = 1'b1;
  // hold off items until the power-on sweep has blanked the store
  assign full = cmd_full || booting;

  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd_in)
  );

  // command queue between decoder and executor
  tcw_fifo #(
    .DW    ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && !booting),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  tcw_exec #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .booting_o   (booting)
  );

  // result queue; the executor only starts an item when a slot is free
  tcw_fifo #(
    .DW    ($bits(out_item_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule
